// ===== src/cubic_bezier_evaluator_assert.svh =====
// Assertion macros shared by the cubic Bezier evaluator RTL.
// Define ASSERT_OFF to compile every check out; no other dependencies.
`ifndef CUBIC_BEZIER_EVALUATOR_ASSERT_SVH
`define CUBIC_BEZIER_EVALUATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define CBZ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbz: same-cycle check failed");
// next-cycle implication
`define CBZ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbz: next-cycle check failed");
`else
`define CBZ_ASSERT_SAME(label, clk, rst, ante, cons)
`define CBZ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/cbz_pkg.sv =====
// Shared constants, request codes and pipeline control type for the
// cubic Bezier evaluator. No dependencies.
`timescale 1ns / 1ps
package cbz_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int T_FRAC_BITS_DEF = 16;
   localparam int OUT_WIDTH       = 24;
   localparam int NUM_REGS        = 8;
   localparam int NUM_TERMS       = 4;
   localparam int NUM_STAGES      = 8;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_ADDR_WIDTH  = $clog2(NUM_REGS) + 2;

   // request types
   localparam logic [1:0] REQ_POINT = 2'd0;
   localparam logic [1:0] REQ_SLOPE = 2'd1;
   localparam logic [1:0] REQ_CURVE = 2'd2;

   // register indexes
   localparam logic [2:0] REG_P0_X = 3'd0;
   localparam logic [2:0] REG_P0_Y = 3'd1;
   localparam logic [2:0] REG_P1_X = 3'd2;
   localparam logic [2:0] REG_P1_Y = 3'd3;
   localparam logic [2:0] REG_P2_X = 3'd4;
   localparam logic [2:0] REG_P2_Y = 3'd5;
   localparam logic [2:0] REG_P3_X = 3'd6;
   localparam logic [2:0] REG_P3_Y = 3'd7;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctl_type;

endpackage

// ===== src/cbz_csr.sv =====
// APB-style register file for the four control points.
// Depends on cbz_pkg.
`timescale 1ns / 1ps
module cbz_csr import cbz_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output logic [COORD_WIDTH-1:0]    coord [NUM_REGS]
);

   localparam int IDX_WIDTH = $clog2(NUM_REGS);

   logic [COORD_WIDTH-1:0] regs_ff [NUM_REGS];
   logic [IDX_WIDTH-1:0]   index;
   logic                   wr_en;

   assign index  = paddr[2 +: IDX_WIDTH];
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign prdata = CSR_DATA_WIDTH'(regs_ff[index]);
   assign coord  = regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (wr_en) begin
         regs_ff[index] <= pwdata[COORD_WIDTH-1:0];
      end
   end

endmodule

// ===== src/cbz_weights.sv =====
// Basis weight pipeline: clamps t, forms u = 1 - t, squares, cubes and
// selects the four weights for the request type. Depends on cbz_pkg.
`timescale 1ns / 1ps
module cbz_weights import cbz_pkg::*; #(
   parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  pipe_ctl_type             ctl,
   input  logic [1:0]               req_type,
   input  logic [T_FRAC_BITS:0]     t_value,
   output logic [1:0]               type_s1,
   output logic [3*T_FRAC_BITS+1:0] weight [NUM_TERMS]
);

   localparam int TW = T_FRAC_BITS + 1;
   localparam int SW = 2 * T_FRAC_BITS + 1;
   localparam int WW = 3 * T_FRAC_BITS + 2;
   localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;

   logic [TW-1:0] t_sat;
   logic [1:0]    type0_ff, type1_ff;
   logic [TW-1:0] t0_ff, u0_ff, t1_ff, u1_ff;
   logic [SW-1:0] uu1_ff, ut1_ff, tt1_ff;
   logic [WW-1:0] m_uuu, m_uut, m_utt, m_ttt;
   logic [WW-1:0] w_in [NUM_TERMS];
   logic [WW-1:0] w_ff [NUM_TERMS];

   // t above one saturates to one
   assign t_sat = (t_value > T_ONE) ? T_ONE : t_value;

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         type0_ff <= req_type;
         t0_ff    <= t_sat;
         u0_ff    <= T_ONE - t_sat;
      end
      if (ctl.load[1]) begin
         type1_ff <= type0_ff;
         t1_ff    <= t0_ff;
         u1_ff    <= u0_ff;
         uu1_ff   <= SW'(u0_ff) * SW'(u0_ff);
         ut1_ff   <= SW'(u0_ff) * SW'(t0_ff);
         tt1_ff   <= SW'(t0_ff) * SW'(t0_ff);
      end
      if (ctl.load[2]) begin
         w_ff <= w_in;
      end
   end

   always_comb begin
      m_uuu = WW'(uu1_ff) * WW'(u1_ff);
      m_uut = WW'(uu1_ff) * WW'(t1_ff);
      m_utt = WW'(tt1_ff) * WW'(u1_ff);
      m_ttt = WW'(tt1_ff) * WW'(t1_ff);
      w_in  = '{default: '0};
      unique case (type1_ff)
         REQ_POINT: begin
            w_in[0] = m_uuu;
            w_in[1] = (m_uut << 1) + m_uut;
            w_in[2] = (m_utt << 1) + m_utt;
            w_in[3] = m_ttt;
         end
         REQ_SLOPE: begin
            w_in[0] = (WW'(uu1_ff) << 1) + WW'(uu1_ff);
            w_in[1] = (WW'(ut1_ff) << 2) + (WW'(ut1_ff) << 1);
            w_in[2] = (WW'(tt1_ff) << 1) + WW'(tt1_ff);
         end
         REQ_CURVE: begin
            w_in[0] = (WW'(u1_ff) << 2) + (WW'(u1_ff) << 1);
            w_in[1] = (WW'(t1_ff) << 2) + (WW'(t1_ff) << 1);
         end
         default: begin
            w_in = '{default: '0};
         end
      endcase
   end

   assign type_s1 = type1_ff;
   assign weight  = w_ff;

endmodule

// ===== src/cbz_axis.sv =====
// One coordinate axis: coefficient select, split weight products, term
// merge, adder tree and round-half-up output register. Depends on cbz_pkg.
`timescale 1ns / 1ps
module cbz_axis import cbz_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  pipe_ctl_type                  ctl,
   input  logic [1:0]                    type_s1,
   input  logic signed [COORD_WIDTH-1:0] pt [NUM_TERMS],
   input  logic [3*T_FRAC_BITS+1:0]      weight [NUM_TERMS],
   output logic signed [OUT_WIDTH-1:0]   result
);

   localparam int AW     = COORD_WIDTH + 2;
   localparam int WW     = 3 * T_FRAC_BITS + 2;
   localparam int HW     = (WW + 1) / 2;
   localparam int UW     = WW - HW;
   localparam int LPW    = AW + HW + 1;
   localparam int HPW    = AW + UW + 1;
   localparam int PRW    = AW + WW;
   localparam int PAIR_W = PRW + 1;
   localparam int SUM_W  = PRW + 2;
   localparam int ACC_WIDTH = (PRW + 3 > 3 * T_FRAC_BITS + OUT_WIDTH) ?
                              PRW + 3 : 3 * T_FRAC_BITS + OUT_WIDTH;
   localparam logic signed [ACC_WIDTH-1:0] HALF_POINT =
      ACC_WIDTH'(1) <<< (3 * T_FRAC_BITS - 1);
   localparam logic signed [ACC_WIDTH-1:0] HALF_SLOPE =
      ACC_WIDTH'(1) <<< (2 * T_FRAC_BITS - 1);
   localparam logic signed [ACC_WIDTH-1:0] HALF_CURVE =
      ACC_WIDTH'(1) <<< (T_FRAC_BITS - 1);

   logic signed [AW-1:0]        pe [NUM_TERMS];
   logic signed [AW-1:0]        coef_in [NUM_TERMS];
   logic signed [AW-1:0]        coef_ff [NUM_TERMS];
   logic signed [LPW-1:0]       lo_in [NUM_TERMS];
   logic signed [LPW-1:0]       lo_ff [NUM_TERMS];
   logic signed [HPW-1:0]       hi_in [NUM_TERMS];
   logic signed [HPW-1:0]       hi_ff [NUM_TERMS];
   logic signed [PRW-1:0]       term_in [NUM_TERMS];
   logic signed [PRW-1:0]       term_ff [NUM_TERMS];
   logic signed [PAIR_W-1:0]    pair_ff [2];
   logic signed [SUM_W-1:0]     sum_ff;
   logic signed [ACC_WIDTH-1:0] ext, rnd;
   logic signed [OUT_WIDTH-1:0] out_in, out_ff;
   logic [1:0]                  type2_ff, type3_ff, type4_ff, type5_ff, type6_ff;

   // coefficients per request type
   always_comb begin
      for (int i = 0; i < NUM_TERMS; i++) begin
         pe[i] = AW'(pt[i]);
      end
      coef_in = '{default: '0};
      unique case (type_s1)
         REQ_POINT: begin
            coef_in = pe;
         end
         REQ_SLOPE: begin
            coef_in[0] = pe[1] - pe[0];
            coef_in[1] = pe[2] - pe[1];
            coef_in[2] = pe[3] - pe[2];
         end
         REQ_CURVE: begin
            coef_in[0] = pe[2] - (pe[1] <<< 1) + pe[0];
            coef_in[1] = pe[3] - (pe[2] <<< 1) + pe[1];
         end
         default: begin
            coef_in = '{default: '0};
         end
      endcase
   end

   // split each weight into halves to keep the multipliers narrow
   always_comb begin
      for (int i = 0; i < NUM_TERMS; i++) begin
         lo_in[i] = LPW'(coef_ff[i]) * LPW'($signed({1'b0, weight[i][HW-1:0]}));
         hi_in[i] = HPW'(coef_ff[i]) * HPW'($signed({1'b0, weight[i][WW-1:HW]}));
         term_in[i] = (PRW'(hi_ff[i]) <<< HW) + PRW'(lo_ff[i]);
      end
   end

   // add half an output LSB, then keep the bits above the fraction
   always_comb begin
      ext = ACC_WIDTH'(sum_ff);
      rnd = ext;
      out_in = '0;
      unique case (type6_ff)
         REQ_POINT: begin
            rnd    = ext + HALF_POINT;
            out_in = rnd[3 * T_FRAC_BITS +: OUT_WIDTH];
         end
         REQ_SLOPE: begin
            rnd    = ext + HALF_SLOPE;
            out_in = rnd[2 * T_FRAC_BITS +: OUT_WIDTH];
         end
         REQ_CURVE: begin
            rnd    = ext + HALF_CURVE;
            out_in = rnd[T_FRAC_BITS +: OUT_WIDTH];
         end
         default: begin
            out_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         coef_ff  <= coef_in;
         type2_ff <= type_s1;
      end
      if (ctl.load[3]) begin
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         type3_ff <= type2_ff;
      end
      if (ctl.load[4]) begin
         term_ff  <= term_in;
         type4_ff <= type3_ff;
      end
      if (ctl.load[5]) begin
         pair_ff[0] <= PAIR_W'(term_ff[0]) + PAIR_W'(term_ff[1]);
         pair_ff[1] <= PAIR_W'(term_ff[2]) + PAIR_W'(term_ff[3]);
         type5_ff   <= type4_ff;
      end
      if (ctl.load[6]) begin
         sum_ff   <= SUM_W'(pair_ff[0]) + SUM_W'(pair_ff[1]);
         type6_ff <= type5_ff;
      end
      if (ctl.load[7]) begin
         out_ff <= out_in;
      end
   end

   assign result = out_ff;

endmodule

// ===== src/cubic_bezier_evaluator.sv =====
// Cubic Bezier evaluator: point, first or second derivative per item.
// Pipeline: eight register stages from the accepting edge to result valid.
// Throughput: one item per cycle unless rsp_stall holds the output; each stage
// hands off when the next is free, so empty stages fill during an output stall.
// Reset clears the stage valid bits and sets all control points to zero.
`timescale 1ns / 1ps
`include "cubic_bezier_evaluator_assert.svh"
module cubic_bezier_evaluator import cbz_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_type,
   input  logic [T_FRAC_BITS:0]        req_t_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [OUT_WIDTH-1:0] rsp_out_x,
   output logic signed [OUT_WIDTH-1:0] rsp_out_y,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [CSR_DATA_WIDTH-1:0]   prdata,
   output logic                        pready
);

   localparam int WW = 3 * T_FRAC_BITS + 2;

   logic [NUM_STAGES-1:0]         valid_ff, valid_in;
   logic [NUM_STAGES:0]           ready;
   pipe_ctl_type                  ctl;
   logic [1:0]                    type_s1;
   logic [WW-1:0]                 weight [NUM_TERMS];
   logic [COORD_WIDTH-1:0]        coord [NUM_REGS];
   logic signed [COORD_WIDTH-1:0] pt_x [NUM_TERMS];
   logic signed [COORD_WIDTH-1:0] pt_y [NUM_TERMS];

   // a stage advances when it is empty or its successor advances
   always_comb begin
      ready[NUM_STAGES] = !rsp_stall;
      for (int s = NUM_STAGES - 1; s >= 0; s--) begin
         ready[s] = !valid_ff[s] || ready[s+1];
      end
      valid_in = valid_ff;
      for (int s = 0; s < NUM_STAGES; s++) begin
         if (ready[s]) begin
            valid_in[s] = (s == 0) ? req_valid : valid_ff[(s == 0) ? 0 : s - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.load  = ready[NUM_STAGES-1:0];
   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   assign pt_x[0] = coord[REG_P0_X];
   assign pt_x[1] = coord[REG_P1_X];
   assign pt_x[2] = coord[REG_P2_X];
   assign pt_x[3] = coord[REG_P3_X];
   assign pt_y[0] = coord[REG_P0_Y];
   assign pt_y[1] = coord[REG_P1_Y];
   assign pt_y[2] = coord[REG_P2_Y];
   assign pt_y[3] = coord[REG_P3_Y];

   cbz_csr #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .coord   (coord)
   );

   cbz_weights #(
      .T_FRAC_BITS(T_FRAC_BITS)
   ) u_weights (
      .clock    (clock),
      .ctl      (ctl),
      .req_type (req_type),
      .t_value  (req_t_value),
      .type_s1  (type_s1),
      .weight   (weight)
   );

   cbz_axis #(
      .COORD_WIDTH(COORD_WIDTH),
      .T_FRAC_BITS(T_FRAC_BITS)
   ) u_axis_x (
      .clock   (clock),
      .ctl     (ctl),
      .type_s1 (type_s1),
      .pt      (pt_x),
      .weight  (weight),
      .result  (rsp_out_x)
   );

   cbz_axis #(
      .COORD_WIDTH(COORD_WIDTH),
      .T_FRAC_BITS(T_FRAC_BITS)
   ) u_axis_y (
      .clock   (clock),
      .ctl     (ctl),
      .type_s1 (type_s1),
      .pt      (pt_y),
      .weight  (weight),
      .result  (rsp_out_y)
   );

   // input is held back only when every stage is occupied
   `CBZ_ASSERT_SAME(a_stall_full, clock, reset, req_stall, &valid_ff)
   // items in flight change only by accepts on either side
   `CBZ_ASSERT_NEXT(a_occupancy, clock, reset, 1'b1, $countones(valid_ff) == $past($countones(valid_ff)) + $past(req_valid && !req_stall) - $past(rsp_valid && !rsp_stall))
   // a new result comes from the stage before the output
   `CBZ_ASSERT_SAME(a_out_source, clock, reset, $rose(rsp_valid), $past(valid_ff[NUM_STAGES-2]))

endmodule
